/* rtl/mhpq_pkg.sv */
// shared types, codes and constants for the max-heap priority queue
package mhpq_pkg;

  localparam int DEFAULT_CAPACITY = 64;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  localparam logic signed [VALUE_W-1:0] INT_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] removed_value;
    logic signed [VALUE_W-1:0] top_value;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
    logic [1:0]                status;
  } out_word_t;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

/* rtl/mhpq_cell.sv */
// one cell of the sorted row: holds one entry, shifts with its neighbours
module mhpq_cell
  import mhpq_pkg::*;
#(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic                      clk,
  input  cell_cmd_t                 cmd,
  input  logic [CNT_W-1:0]          count,
  input  logic                      prev_ge,
  input  logic signed [VALUE_W-1:0] prev_val,
  input  logic signed [VALUE_W-1:0] next_val,
  output logic                      ge,
  output logic signed [VALUE_W-1:0] val
);

  logic signed [VALUE_W-1:0] val_r;
  logic signed [VALUE_W-1:0] val_nxt;
  logic                      occupied;

  assign occupied = count > CNT_W'(IDX);
  assign ge       = occupied && (val_r >= cmd.value);
  assign val      = val_r;

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (ge) begin
        val_nxt = val_r;
      end else if (prev_ge) begin
        val_nxt = cmd.value;
      end else begin
        val_nxt = prev_val;
      end
    end else if (cmd.rem) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* rtl/max_heap_priority_queue.sv */
// top level of the max-heap priority queue: row of sorted cells plus result register
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------------
//  in_     | input     | in_valid / in_ready   | op, value
//  out_    | output    | out_valid / out_ready | removed_value, top_value, count,
//          |           |                       | is_empty, status
//
// one word is taken per cycle while in_ready is high; its result shows in the output register in the cycle after
// each word is applied by the single compare-and-shift step of the cell row, which
// holds the entries sorted largest first so the maximum always sits in cell 0
// rst_n (synchronous) empties the queue and the output register; entry data is not cleared
// in_ready drops only while a result waits and out_ready is low
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  // count must hold the full capacity itself
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  out_word_t        out_word_r;
  out_word_t        out_word_nxt;

  logic                      accept;
  logic                      is_full;
  logic                      is_none;
  cell_cmd_t                 cmd;
  logic signed [VALUE_W-1:0] cell_val [CAPACITY];
  logic                      cell_ge  [CAPACITY];

  // a new word may enter whenever the output register is free or being emptied
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_full = count_r == CNT_W'(CAPACITY);
  assign is_none = count_r == '0;

  // dropped inserts and removes from an empty queue leave the row untouched
  assign cmd.ins   = accept && (in_word.op == OP_INSERT) && !is_full;
  assign cmd.rem   = accept && (in_word.op == OP_REMOVE) && !is_none;
  assign cmd.value = in_word.value;

  // row of cells, cell 0 holds the maximum
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      prev_ge;
    logic signed [VALUE_W-1:0] prev_val;
    logic signed [VALUE_W-1:0] next_val;

    if (i == 0) begin : g_head
      // the head always takes the new value when it loses the compare
      assign prev_ge  = 1'b1;
      assign prev_val = cmd.value;
    end else begin : g_body
      assign prev_ge  = cell_ge[i-1];
      assign prev_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end

    mhpq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .count    (count_r),
      .prev_ge  (prev_ge),
      .prev_val (prev_val),
      .next_val (next_val),
      .ge       (cell_ge[i]),
      .val      (cell_val[i])
    );
  end

  // result word, worked out from the row as it stands before the update
  always_comb begin
    count_nxt                  = count_r;
    out_word_nxt.removed_value = '0;
    out_word_nxt.top_value     = is_none ? INT_MIN : cell_val[0];
    out_word_nxt.status        = STATUS_OK;
    if (in_word.op == OP_INSERT) begin
      if (is_full) begin
        out_word_nxt.status = STATUS_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if (is_none || (in_word.value > cell_val[0])) begin
          out_word_nxt.top_value = in_word.value;
        end
      end
    end else begin
      if (is_none) begin
        out_word_nxt.removed_value = INT_MIN;
        out_word_nxt.status        = STATUS_EMPTY;
      end else begin
        count_nxt                  = count_r - CNT_W'(1);
        out_word_nxt.removed_value = cell_val[0];
        // second cell becomes the head when more than one entry was held
        out_word_nxt.top_value     = (count_r > CNT_W'(1)) ? cell_val[1] : INT_MIN;
      end
    end
    // count field keeps its low bits only
    out_word_nxt.count    = COUNT_W'(count_nxt);
    out_word_nxt.is_empty = count_nxt == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register, loaded on every accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/mhpq_checker.sv */
// port-level checks for the max-heap priority queue, bound to the top level
module mhpq_checker
  import mhpq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // every accepted word gives a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word gave no result");

  // an empty queue reports the most negative value as maximum and a count of zero
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.is_empty |-> out_word.top_value == INT_MIN
      && out_word.count == '0)
    else $error("empty queue with a top value or count");

  // removing from an empty queue reports underflow consistently
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == STATUS_EMPTY |->
      out_word.removed_value == INT_MIN && out_word.is_empty)
    else $error("underflow word inconsistent");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

/* verif/max_heap_priority_queue_checker.sv */
// scoreboard for the max-heap priority queue: predicts each result word and checks it
module max_heap_priority_queue_checker
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending
);

  logic signed [VALUE_W-1:0] heap_mem [CAPACITY];
  int                        heap_len;
  out_word_t                 predicted_results [$];

  // applies one word to the heap copy and returns the result word it must produce
  function automatic out_word_t apply_heap_op(in_word_t w);
    out_word_t                 r;
    int                        pos;
    int                        parent;
    int                        best;
    int                        child;
    logic signed [VALUE_W-1:0] tmp;
    r = '0;
    r.status = STATUS_OK;
    if (w.op == OP_INSERT) begin
      if (heap_len >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        pos = heap_len;
        heap_mem[pos] = w.value;
        heap_len++;
        // climb while the parent is strictly smaller
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_mem[parent] >= heap_mem[pos]) break;
          tmp = heap_mem[parent];
          heap_mem[parent] = heap_mem[pos];
          heap_mem[pos] = tmp;
          pos = parent;
        end
      end
    end else if (heap_len == 0) begin
      r.removed_value = INT_MIN;
      r.status = STATUS_EMPTY;
    end else begin
      r.removed_value = heap_mem[0];
      heap_len--;
      heap_mem[0] = heap_mem[heap_len];
      pos = 0;
      // sink towards the larger child, left wins on a tie
      forever begin
        best = pos;
        child = 2 * pos + 1;
        if (child < heap_len && heap_mem[child] > heap_mem[best]) best = child;
        if (child + 1 < heap_len && heap_mem[child + 1] > heap_mem[best]) best = child + 1;
        if (best == pos) break;
        tmp = heap_mem[best];
        heap_mem[best] = heap_mem[pos];
        heap_mem[pos] = tmp;
        pos = best;
      end
    end
    r.top_value = (heap_len > 0) ? heap_mem[0] : INT_MIN;
    r.count = COUNT_W'(heap_len);
    r.is_empty = (heap_len == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      heap_len = 0;
      fail_count = 0;
      predicted_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: removed=%0d top=%0d",
                     out_word.removed_value, out_word.top_value,
                     " count=%0d empty=%0b status=%0d",
                     out_word.count, out_word.is_empty, out_word.status);
        end else begin
          want = predicted_results.pop_front();
          if (out_word.removed_value !== want.removed_value ||
              out_word.top_value !== want.top_value ||
              out_word.count !== want.count ||
              out_word.is_empty !== want.is_empty ||
              out_word.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected removed=%0d top=%0d",
                       want.removed_value, want.top_value,
                       " count=%0d empty=%0b status=%0d,",
                       want.count, want.is_empty, want.status,
                       " got removed=%0d top=%0d",
                       out_word.removed_value, out_word.top_value,
                       " count=%0d empty=%0b status=%0d",
                       out_word.count, out_word.is_empty, out_word.status);
          end
        end
      end
      if (in_valid && in_ready) predicted_results = {predicted_results, apply_heap_op(in_word)};
    end
    pending = predicted_results.size();
  end

endmodule

/* verif/max_heap_priority_queue_test.sv */
// testbench top for the max-heap priority queue: stimulus, flow control and verdict
module max_heap_priority_queue_test;
  import mhpq_pkg::*;

  localparam int RANDOM_WORDS = 1950;
  // far beyond the slowest legal run of about 2000 words
  localparam int TIME_LIMIT = 2000000;

  typedef enum {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_TOGGLE
  } rx_mode_t;

  typedef enum {
    SEG_FILL,
    SEG_DRAIN,
    SEG_MIXED
  } seg_kind_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  int        fail_count;
  int        pending;

  int        burst_left = 25;  // words still to go in the current sender burst
  rx_mode_t  rx_mode = RX_OPEN;
  int        rx_mode_left = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  max_heap_priority_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  max_heap_priority_queue_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // receiver back-pressure: a randomly chosen pattern, held for a random stretch and then redrawn,
  // ranging from fully open through coin-flip and sparse to a strict toggle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(30, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN: begin
          out_ready <= 1'b1;
        end
        RX_COIN: begin
          out_ready <= 1'($urandom_range(0, 1));
        end
        RX_SPARSE: begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_ready <= ~out_ready;
        end
      endcase
    end
  end

  // present one word and hold it until the block takes it; at the end of a burst
  // valid drops for a random gap
  task automatic send_word(input op_t kind, input logic signed [VALUE_W-1:0] operand);
    in_valid <= 1'b1;
    in_word <= '{op: kind, value: operand};
    do @(posedge clk); while (in_ready !== 1'b1);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // now and then a long burst so that stretches run with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 20);
    end
  endtask

  // hold off the sender until every predicted result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // value mix: full range, a narrow band for plenty of ties, and the extremes
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 7) return $urandom_range(0, 15) - 8;
    if (sel < 8) return INT_MIN + $urandom_range(0, 3);
    if (sel < 9) return 32'sh7fffffff - $urandom_range(0, 3);
    return ($urandom_range(0, 1) != 0) ? 32'sd0 : -32'sd1;
  endfunction

  initial begin
    int        sent;
    int        seg_len;
    int        insert_pct;
    int        seg_idx;
    seg_kind_t seg_kind;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: remove from an empty queue first
    send_word(OP_REMOVE, $urandom);
    // extremes and duplicates, including a tie at the top
    send_word(OP_INSERT, 32'sd0);
    send_word(OP_INSERT, INT_MIN);
    send_word(OP_INSERT, 32'sh7fffffff);
    send_word(OP_INSERT, -32'sd1);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_INSERT, 32'sd5);
    send_word(OP_INSERT, 32'sh7fffffff);
    // drain everything, the last remove runs dry again; value on remove is junk
    repeat (8) send_word(OP_REMOVE, $urandom);
    // most negative value stored, then taken back out so it looks like an empty top
    send_word(OP_INSERT, INT_MIN);
    send_word(OP_REMOVE, $urandom);
    send_word(OP_REMOVE, $urandom);
    wait_drained();

    // random: rotate fill, drain and mixed segments so the queue repeatedly runs
    // up to full (dropped inserts) and down to empty (removes on empty)
    sent = 0;
    seg_idx = 0;
    while (sent < RANDOM_WORDS) begin
      seg_kind = seg_kind_t'(seg_idx % 3);
      case (seg_kind)
        SEG_FILL: begin
          insert_pct = 95;
          seg_len = $urandom_range(70, 140);
        end
        SEG_DRAIN: begin
          insert_pct = 5;
          seg_len = $urandom_range(70, 140);
        end
        default: begin
          insert_pct = 55;
          seg_len = $urandom_range(40, 120);
        end
      endcase
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < insert_pct) send_word(OP_INSERT, pick_value());
        else send_word(OP_REMOVE, $urandom);
        sent++;
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
      seg_idx++;
    end

    wait_drained();
    // a short tail to catch any stray results
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIME_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
